// ===== design/sk2c_pkg.sv =====
// ----------------------------------------------------------------------------
// sk2c_pkg
// Shared constants of the square kernel 2-D convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package sk2c_pkg;

  localparam int HEIGHT_MAX = 1024;
  localparam int COEF_DEPTH = 81;
  localparam int FIFO_DEPTH = 8;

  localparam logic [1:0] REG_EXTENT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic KIND_COEF  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  typedef logic [32:0] res_t;

endpackage

`default_nettype wire

// ===== design/square_kernel_2d_convolution.sv =====
// ----------------------------------------------------------------------------
// square_kernel_2d_convolution
// Streaming 2-D FIR over a border-extended raster image, square kernel.
// ----------------------------------------------------------------------------
// Pipeline: column memory (stage 1), products, row sums, total, output queue.
// Throughput: one request per cycle while credit leaves in_ready high; set by
//   the column memory read-modify-write and the parallel 81-tap multiply tree.
// Reset: synchronous, clears counters, coefficients, window, queue and config
//   to the reset values; the column memory is not cleared.
`default_nettype none

module square_kernel_2d_convolution #(
  parameter int MAX_EXTENT = 4,
  parameter int MAX_WIDTH  = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [6:0]  coeff_index,
  input  wire logic signed [15:0] coeff_value,
  input  wire logic [7:0]  pixel,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [31:0] filtered_value,
  output logic             last_of_image,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);
  import sk2c_pkg::*;

  localparam int SIDE_MAX = 2 * MAX_EXTENT + 1;
  localparam int LINES    = 2 * MAX_EXTENT;
  localparam int ROW_MAX  = MAX_WIDTH + 2 * MAX_EXTENT;
  localparam int CW       = $clog2(ROW_MAX + 1);
  localparam int AW       = $clog2(ROW_MAX);
  localparam int RW       = $clog2(HEIGHT_MAX + 2 * MAX_EXTENT + 1);
  localparam int EW       = $clog2(MAX_EXTENT + 1);
  localparam int CDEPTH   = (SIDE_MAX * SIDE_MAX < COEF_DEPTH) ?
                            SIDE_MAX * SIDE_MAX : COEF_DEPTH;
  localparam int QW       = $clog2(FIFO_DEPTH);
  localparam int NW       = $clog2(FIFO_DEPTH + 1);

  // configuration
  logic [2:0]  kernel_extent;
  logic [10:0] out_width;
  logic [10:0] out_height;

  logic [EW-1:0] ext_eff;
  logic [CW-1:0] w_tot;
  logic [RW-1:0] h_tot;
  logic [CW-1:0] lines_c;

  always_comb begin
    int e, wv, hv;
    e  = (int'(kernel_extent) > MAX_EXTENT) ? MAX_EXTENT : int'(kernel_extent);
    wv = (out_width == 11'd0) ? 1 :
         ((int'(out_width) > MAX_WIDTH) ? MAX_WIDTH : int'(out_width));
    hv = (out_height == 11'd0) ? 1 :
         ((int'(out_height) > HEIGHT_MAX) ? HEIGHT_MAX : int'(out_height));
    ext_eff = EW'(e);
    w_tot   = CW'(wv + 2 * e);
    h_tot   = RW'(hv + 2 * e);
    lines_c = CW'(2 * e);
  end

  assign cfg_ready = 1'b1;

  // request accept and raster position
  logic [AW-1:0] col_cnt;
  logic [RW-1:0] row_cnt;
  logic [NW-1:0] credit;
  logic          acc;
  logic          acc_pix;
  logic          acc_emit;
  logic          acc_last;

  assign in_ready = (credit < NW'(FIFO_DEPTH));
  assign acc      = in_valid && in_ready;
  assign acc_pix  = acc && (kind == KIND_PIXEL);
  assign acc_emit = acc_pix && (RW'(lines_c) <= row_cnt) && (lines_c <= CW'(col_cnt));
  assign acc_last = (row_cnt == h_tot - RW'(1)) && (CW'(col_cnt) == w_tot - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_extent <= 3'd1;
      out_width     <= 11'd1024;
      out_height    <= 11'd1024;
      col_cnt       <= '0;
      row_cnt       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_EXTENT: kernel_extent <= cfg_data[2:0];
        REG_WIDTH:  out_width     <= cfg_data;
        REG_HEIGHT: out_height    <= cfg_data;
        default: ;
      endcase
      if (cfg_index == REG_EXTENT || cfg_index == REG_WIDTH ||
          cfg_index == REG_HEIGHT) begin
        col_cnt <= '0;
        row_cnt <= '0;
      end
    end else if (acc_pix) begin
      if (CW'(col_cnt) + CW'(1) >= w_tot) begin
        col_cnt <= '0;
        row_cnt <= (row_cnt + RW'(1) >= h_tot) ? '0 : row_cnt + RW'(1);
      end else begin
        col_cnt <= col_cnt + AW'(1);
      end
    end
  end

  // stage 1: column memory read data arrives; read-modify-write
  logic [8*LINES-1:0] col_mem [ROW_MAX];
  logic [8*LINES-1:0] rd_data;
  logic [8*LINES-1:0] fwd_data;
  logic [8*LINES-1:0] old_word;
  logic [8*LINES-1:0] new_word;
  logic               fwd;

  logic               s1_valid;
  logic               s1_kind;
  logic               s1_emit;
  logic               s1_last;
  logic [AW-1:0]      s1_addr;
  logic [7:0]         s1_pixel;
  logic [6:0]         s1_cidx;
  logic signed [15:0] s1_cval;

  logic               s1_pix;
  assign s1_pix = s1_valid && (s1_kind == KIND_PIXEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_kind  <= kind;
      s1_emit  <= acc_emit;
      s1_last  <= acc_last;
      s1_addr  <= col_cnt;
      s1_pixel <= pixel;
      s1_cidx  <= coeff_index;
      s1_cval  <= coeff_value;
    end
    if (acc_pix) begin
      rd_data  <= col_mem[col_cnt];
      // same column written back at this very edge: take the fresh word
      fwd      <= s1_pix && (s1_addr == col_cnt);
      fwd_data <= new_word;
    end
    if (s1_pix) begin
      col_mem[s1_addr] <= new_word;
    end
  end

  assign old_word = fwd ? fwd_data : rd_data;

  logic [7:0] col_new [SIDE_MAX];

  always_comb begin
    for (int k = 0; k < LINES; k++) begin
      if (k + 1 < int'(lines_c))       new_word[8*k +: 8] = old_word[8*(k+1) +: 8];
      else if (k + 1 == int'(lines_c)) new_word[8*k +: 8] = s1_pixel;
      else                             new_word[8*k +: 8] = old_word[8*k +: 8];
    end
    for (int dy = 0; dy < SIDE_MAX; dy++) begin
      if (dy < int'(lines_c))       col_new[dy] = old_word[8*(dy % LINES) +: 8];
      else if (dy == int'(lines_c)) col_new[dy] = s1_pixel;
      else                          col_new[dy] = 8'd0;
    end
  end

  // window and coefficients
  logic [7:0]         win      [SIDE_MAX][SIDE_MAX];
  logic [7:0]         win_next [SIDE_MAX][SIDE_MAX];
  logic signed [15:0] coef     [CDEPTH];
  logic signed [15:0] tap      [SIDE_MAX][SIDE_MAX];

  always_comb begin
    int side;
    side = 2 * int'(ext_eff) + 1;
    for (int dy = 0; dy < SIDE_MAX; dy++) begin
      for (int dx = 0; dx < SIDE_MAX; dx++) begin
        if (dy < side && dx < side) begin
          if (dx == side - 1) win_next[dy][dx] = col_new[dy];
          else                win_next[dy][dx] = win[dy][(dx + 1) % SIDE_MAX];
        end else begin
          win_next[dy][dx] = win[dy][dx];
        end
      end
    end
  end

  // each tap picks its coefficient per extent from fixed store positions
  always_comb begin
    for (int dy = 0; dy < SIDE_MAX; dy++) begin
      for (int dx = 0; dx < SIDE_MAX; dx++) begin
        tap[dy][dx] = '0;
        for (int e = 0; e <= MAX_EXTENT; e++) begin
          if (int'(ext_eff) == e && dy < 2 * e + 1 && dx < 2 * e + 1 &&
              dy * (2 * e + 1) + dx < CDEPTH) begin
            tap[dy][dx] = coef[(dy * (2 * e + 1) + dx) % CDEPTH];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CDEPTH; i++) coef[i] <= '0;
    end else if (s1_valid && s1_kind == KIND_COEF && int'(s1_cidx) < CDEPTH) begin
      coef[s1_cidx] <= s1_cval;
    end
  end

  // window shifts once per pixel; cells outside the current side hold
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int dy = 0; dy < SIDE_MAX; dy++) begin
        for (int dx = 0; dx < SIDE_MAX; dx++) win[dy][dx] <= '0;
      end
    end else if (s1_pix) begin
      win <= win_next;
    end
  end

  // stage 2: products
  logic signed [24:0] prod [SIDE_MAX][SIDE_MAX];
  logic               s2_valid;
  logic               s2_last;

  always_ff @(posedge clk) begin
    for (int dy = 0; dy < SIDE_MAX; dy++) begin
      for (int dx = 0; dx < SIDE_MAX; dx++) begin
        prod[dy][dx] <= $signed({1'b0, win_next[dy][dx]}) * tap[dy][dx];
      end
    end
    s2_last <= s1_last;
  end

  // stage 3: row sums, stage 4: total
  logic signed [31:0] row_sum [SIDE_MAX];
  logic signed [31:0] total;
  logic               s3_valid;
  logic               s3_last;
  logic               s4_valid;
  logic               s4_last;

  always_ff @(posedge clk) begin
    logic signed [31:0] acc_r;
    logic signed [31:0] acc_t;
    for (int dy = 0; dy < SIDE_MAX; dy++) begin
      acc_r = '0;
      for (int dx = 0; dx < SIDE_MAX; dx++) acc_r = acc_r + 32'(prod[dy][dx]);
      row_sum[dy] <= acc_r;
    end
    acc_t = '0;
    for (int dy = 0; dy < SIDE_MAX; dy++) acc_t = acc_t + row_sum[dy];
    total   <= acc_t;
    s3_last <= s2_last;
    s4_last <= s3_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s2_valid <= s1_pix && s1_emit;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // output queue; credit covers results in flight plus queued
  res_t          q_mem [FIFO_DEPTH];
  logic [QW-1:0] q_wp;
  logic [QW-1:0] q_rp;
  logic [NW-1:0] q_cnt;
  logic          q_pop;

  assign out_valid      = (q_cnt != '0);
  assign q_pop          = out_valid && out_ready;
  assign filtered_value = q_mem[q_rp][31:0];
  assign last_of_image  = q_mem[q_rp][32];

  always_ff @(posedge clk) begin
    if (s4_valid) q_mem[q_wp] <= {s4_last, total};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wp   <= '0;
      q_rp   <= '0;
      q_cnt  <= '0;
      credit <= '0;
    end else begin
      if (s4_valid) q_wp <= (int'(q_wp) == FIFO_DEPTH - 1) ? '0 : q_wp + QW'(1);
      if (q_pop)    q_rp <= (int'(q_rp) == FIFO_DEPTH - 1) ? '0 : q_rp + QW'(1);
      q_cnt  <= q_cnt + NW'(s4_valid) - NW'(q_pop);
      credit <= credit + NW'(acc_emit) - NW'(q_pop);
    end
  end

  // checks
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit <= NW'(FIFO_DEPTH))
    else $error("credit overflow");

  a_queue_in_credit: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= credit)
    else $error("queue holds more than reserved");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> (q_cnt < NW'(FIFO_DEPTH)))
    else $error("push into full queue");

endmodule

`default_nettype wire
